/* hdl/delay_line_audio_effects_core_assert.svh */
// assertion macros for the delay-line audio effects core
// expects signals named clock and reset in the module that uses them
`ifndef DELAY_LINE_AUDIO_EFFECTS_CORE_ASSERT_SVH
`define DELAY_LINE_AUDIO_EFFECTS_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DLAE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dlae assertion failed");

// next-cycle implication, disabled during reset
`define DLAE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dlae assertion failed");

`endif

/* hdl/dlae_pkg.sv */
// constants and helpers for the delay-line audio effects core
// no dependencies
package dlae_pkg;

   localparam int DefaultHistoryDepth = 2048;

   // effect mode codes
   localparam logic [1:0] MODE_PASS    = 2'd0;
   localparam logic [1:0] MODE_ECHO    = 2'd1;
   localparam logic [1:0] MODE_REVERB  = 2'd2;
   localparam logic [1:0] MODE_VIBRATO = 2'd3;

   // register indexes
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;
   localparam logic [CsrIndexWidth-1:0] CSR_EFFECT_MODE   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_ECHO_DELAY    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_ECHO_GAIN     = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_VIB_LOW_DELAY = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_VIB_STEP      = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_VIB_HOLD      = 3'd5;

   localparam logic [8:0] UNITY_GAIN = 9'd256;

   // reverb tap delays in samples
   function automatic logic [11:0] reverb_tap(input logic [1:0] k);
      logic [11:0] d;
      case (k)
         2'd0:    d = 12'd220;
         2'd1:    d = 12'd440;
         2'd2:    d = 12'd660;
         default: d = 12'd880;
      endcase
      return d;
   endfunction

   // reverb tap gains, q0.8: 0.3, 0.25, 0.2, 0.15 rounded
   function automatic logic [8:0] reverb_gain(input logic [1:0] k);
      logic [8:0] g;
      case (k)
         2'd0:    g = 9'd77;
         2'd1:    g = 9'd64;
         2'd2:    g = 9'd51;
         default: g = 9'd38;
      endcase
      return g;
   endfunction

endpackage

/* hdl/delay_line_audio_effects_core.sv */
// delay-line audio effects core: pass-through, echo, reverb and vibrato
// depends on dlae_pkg and delay_line_audio_effects_core_assert.svh
//
// One 12-bit sample per transaction in, one processed sample per transaction out.
// Past samples live in a circular history memory of HISTORY_DEPTH entries (one
// write port, one registered read port). The four reverb tap reads go through the
// single read port one per cycle, and every mode runs the same phase sequence. The
// first read is issued in the accept cycle, and the next transaction is accepted
// in the cycle its predecessor writes back, so the core does not take a new sample
// before the previous one writes back.
// A finished result waits in the output register while the next sample is
// already being worked on. The history reads as zero where it was never written;
// a fill count tracks that, so there is no clearing pass after reset. Config
// writes are expected only while the core is idle.
module delay_line_audio_effects_core
   import dlae_pkg::*;
#(
   parameter int HISTORY_DEPTH = DefaultHistoryDepth
) (
   input  logic                     clock,
   input  logic                     reset,
   // sample input
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [11:0]              req_sample_in,
   // processed output
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [11:0]              rsp_sample_out,
   output logic                     rsp_clipped,
   // register writes
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   `include "delay_line_audio_effects_core_assert.svh"

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int FW = $clog2(HISTORY_DEPTH + 1);

   // delay clamped below the history depth
   function automatic logic [AW-1:0] clamp_delay(input logic [11:0] d);
      logic [AW-1:0] r;
      if (32'(d) >= HISTORY_DEPTH) begin
         r = AW'(HISTORY_DEPTH - 1);
      end else begin
         r = AW'(d);
      end
      return r;
   endfunction

   // configuration registers
   logic [1:0]  mode_ff;
   logic [10:0] echo_delay_ff;
   logic [8:0]  echo_gain_ff;
   logic [9:0]  vib_low_ff;
   logic [8:0]  vib_step_ff;
   logic [15:0] vib_hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_PASS;
         echo_delay_ff <= 11'd441;
         echo_gain_ff  <= 9'd128;
         vib_low_ff    <= 10'd441;
         vib_step_ff   <= 9'd88;
         vib_hold_ff   <= 16'd8192;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_EFFECT_MODE:   mode_ff       <= csr_wdata[1:0];
            CSR_ECHO_DELAY:    echo_delay_ff <= csr_wdata[10:0];
            CSR_ECHO_GAIN:     echo_gain_ff  <= csr_wdata[8:0];
            CSR_VIB_LOW_DELAY: vib_low_ff    <= csr_wdata[9:0];
            CSR_VIB_STEP:      vib_step_ff   <= csr_wdata[8:0];
            CSR_VIB_HOLD:      vib_hold_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer and handshake
   logic          busy_ff, busy_in;
   logic [1:0]    phase_ff, phase_in;
   logic          out_free, finish, accept;

   assign out_free  = !rsp_valid || !rsp_stall;
   assign finish    = busy_ff && (phase_ff == 2'd3) && out_free;
   assign req_stall = busy_ff && !finish;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      if (accept) begin
         busy_in  = 1'b1;
         phase_in = 2'd0;
      end else if (finish) begin
         busy_in  = 1'b0;
      end else if (busy_ff && phase_ff != 2'd3) begin
         phase_in = phase_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
      end
   end

   // write position and fill count advance per accepted transaction
   logic [AW-1:0] pos_ff, pos_in;
   logic [FW-1:0] fill_ff, fill_in;

   always_comb begin
      pos_in  = pos_ff;
      fill_in = fill_ff;
      if (accept) begin
         pos_in = (32'(pos_ff) == HISTORY_DEPTH - 1) ? '0 : pos_ff + AW'(1);
         if (32'(fill_ff) < HISTORY_DEPTH) begin
            fill_in = fill_ff + FW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         fill_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         fill_ff <= fill_in;
      end
   end

   // vibrato state, stepped at each vibrato transaction
   logic [15:0] hold_cnt_ff, hold_cnt_in;
   logic [1:0]  vib_level_ff, vib_level_in;
   logic        vib_falling_ff, vib_falling_in;
   logic        vib_started_ff, vib_started_in;
   logic [15:0] hold_eff, hold_next;
   logic [1:0]  level_step;

   always_comb begin
      hold_eff       = (vib_hold_ff == 16'd0) ? 16'd1 : vib_hold_ff;
      hold_next      = hold_cnt_ff + 16'd1;
      hold_cnt_in    = hold_cnt_ff;
      vib_level_in   = vib_level_ff;
      vib_falling_in = vib_falling_ff;
      vib_started_in = vib_started_ff;
      if (!vib_falling_ff) begin
         level_step = (vib_level_ff >= 2'd2) ? 2'd2 : vib_level_ff + 2'd1;
      end else begin
         level_step = (vib_level_ff == 2'd0) ? 2'd0 : vib_level_ff - 2'd1;
      end
      if (accept && mode_ff == MODE_VIBRATO) begin
         if (hold_next < hold_eff) begin
            hold_cnt_in = hold_next;
         end else begin
            hold_cnt_in    = 16'd0;
            vib_started_in = 1'b1;
            vib_level_in   = level_step;
            if (level_step >= 2'd2) begin
               vib_falling_in = 1'b1;
            end
            if (level_step == 2'd0) begin
               vib_falling_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_cnt_ff    <= 16'd0;
         vib_level_ff   <= 2'd1;
         vib_falling_ff <= 1'b0;
         vib_started_ff <= 1'b0;
      end else begin
         hold_cnt_ff    <= hold_cnt_in;
         vib_level_ff   <= vib_level_in;
         vib_falling_ff <= vib_falling_in;
         vib_started_ff <= vib_started_in;
      end
   end

   // per-transaction context captured at accept
   logic [11:0]   x_ff;
   logic [AW-1:0] wpos_ff;
   logic [FW-1:0] ifill_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff     <= req_sample_in;
         wpos_ff  <= pos_ff;
         ifill_ff <= fill_ff;
      end
   end

   // read issue: tap 0 in the accept cycle, taps 1..3 in phases 0..2
   logic          mem_re;
   logic [1:0]    rd_tap;
   logic [AW-1:0] rd_base;
   logic [FW-1:0] rd_fill;
   logic [AW-1:0] rd_delay;
   logic          rd_used;
   logic [AW-1:0] rd_addr;
   logic [AW:0]   rd_wrap;
   logic          rzero_in, rself_in;
   logic [1:0]    vib_lvl;
   logic [11:0]   vib_offset, vib_delay;

   assign mem_re = accept || (busy_ff && phase_ff != 2'd3);

   always_comb begin
      rd_tap  = accept ? 2'd0 : phase_ff + 2'd1;
      rd_base = accept ? pos_ff : wpos_ff;
      rd_fill = accept ? fill_ff : ifill_ff;

      // vibrato delay from the level in effect before this transaction
      vib_lvl = (vib_level_ff > 2'd2) ? 2'd2 : vib_level_ff;
      case (vib_lvl)
         2'd0:    vib_offset = 12'd0;
         2'd1:    vib_offset = {3'd0, vib_step_ff};
         default: vib_offset = {2'd0, vib_step_ff, 1'b0};
      endcase
      vib_delay = {2'd0, vib_low_ff} + vib_offset;

      rd_used  = 1'b0;
      rd_delay = '0;
      case (mode_ff)
         MODE_ECHO: begin
            rd_used  = (rd_tap == 2'd0);
            rd_delay = clamp_delay({1'b0, echo_delay_ff});
         end
         MODE_REVERB: begin
            rd_used  = 1'b1;
            rd_delay = clamp_delay(reverb_tap(rd_tap));
         end
         MODE_VIBRATO: begin
            rd_used  = (rd_tap == 2'd0);
            rd_delay = vib_started_ff ? clamp_delay(vib_delay) : '0;
         end
         default: ;
      endcase

      // circular address behind the write position
      rd_wrap = {1'b0, rd_base} + (AW + 1)'(HISTORY_DEPTH) - {1'b0, rd_delay};
      if (rd_base >= rd_delay) begin
         rd_addr = rd_base - rd_delay;
      end else begin
         rd_addr = rd_wrap[AW-1:0];
      end

      // zero delay means the current input, never-written entries read zero
      rself_in = rd_used && (rd_delay == '0);
      rzero_in = !rd_used || ((rd_delay != '0) && (FW'(rd_delay) > rd_fill));
   end

   // history memory with write-to-read forwarding
   logic [11:0]   history_mem [HISTORY_DEPTH];
   logic [11:0]   mem_q_ff;
   logic          mem_we;
   logic [11:0]   wr_data;
   logic [11:0]   wr_data_ff;
   logic          fwd_ff, rzero_ff, rself_ff;

   assign mem_we = finish;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         history_mem[wpos_ff] <= wr_data;
         wr_data_ff           <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         mem_q_ff <= history_mem[rd_addr];
         fwd_ff   <= mem_we && (wpos_ff == rd_addr);
         rzero_ff <= rzero_in;
         rself_ff <= rself_in;
      end
   end

   // multiply-accumulate, one tap per phase
   logic [11:0] tap_val;
   logic [8:0]  echo_g, coef;
   logic [20:0] prod, acc_ff, acc_in;
   logic [13:0] sum_raw;
   logic [11:0] sum_sat;
   logic        clip;

   always_comb begin
      if (rzero_ff) begin
         tap_val = 12'd0;
      end else if (rself_ff) begin
         tap_val = x_ff;
      end else if (fwd_ff) begin
         tap_val = wr_data_ff;
      end else begin
         tap_val = mem_q_ff;
      end

      echo_g = (echo_gain_ff > UNITY_GAIN) ? UNITY_GAIN : echo_gain_ff;
      coef   = 9'd0;
      case (mode_ff)
         MODE_ECHO:    coef = (phase_ff == 2'd0) ? echo_g : 9'd0;
         MODE_REVERB:  coef = reverb_gain(phase_ff);
         // unity weight on the delayed sample, the input is dropped below
         MODE_VIBRATO: coef = (phase_ff == 2'd0) ? UNITY_GAIN : 9'd0;
         default: ;
      endcase

      prod   = 21'(coef * tap_val);
      acc_in = ((phase_ff == 2'd0) ? 21'd0 : acc_ff) + prod;

      if (mode_ff == MODE_VIBRATO) begin
         sum_raw = {1'b0, acc_in[20:8]};
      end else begin
         sum_raw = {1'b0, acc_in[20:8]} + {2'd0, x_ff};
      end
      clip    = (sum_raw > 14'd4095);
      sum_sat = clip ? 12'd4095 : sum_raw[11:0];
      // reverb feeds back its output, the other modes record the input
      wr_data = (mode_ff == MODE_REVERB) ? sum_sat : x_ff;
   end

   always_ff @(posedge clock) begin
      if (busy_ff && phase_ff != 2'd3) begin
         acc_ff <= acc_in;
      end
   end

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] rsp_sample_ff;
   logic        rsp_clip_ff;

   assign rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_sample_ff <= sum_sat;
         rsp_clip_ff   <= clip;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clip_ff;

   // checks on the sequencer and vibrato state
   `DLAE_ASSERT_NEXT(a_accept_starts, accept, busy_ff && phase_ff == 2'd0)
   `DLAE_ASSERT_NEXT(a_phase_advance, busy_ff && phase_ff != 2'd3 && !accept,
                     busy_ff && phase_ff == 2'($past(phase_ff) + 2'd1))
   `DLAE_ASSERT_NEXT(a_finish_loads_out, finish, rsp_valid_ff)
   `DLAE_ASSERT_SAME(a_vib_level_range, 1'b1, vib_level_ff != 2'd3)

endmodule

/* verif/delay_line_audio_effects_core_test.sv */
`timescale 1ns / 100ps
// self-checking testbench for delay_line_audio_effects_core: directed table, then random phases
// carries its own model of the effects core; depends on dlae_pkg and the core rtl
module delay_line_audio_effects_core_test;
   import dlae_pkg::*;

   localparam int Depth       = DefaultHistoryDepth;
   localparam int IdleLimit   = 2000;   // cycles with no transaction of any kind
   localparam int RandomItems = 950;
   localparam int MaxReports  = 10;

   // fixed reverb taps and their q0.8 gains
   localparam int unsigned ReverbTap  [4] = '{220, 440, 660, 880};
   localparam int unsigned ReverbGain [4] = '{77, 64, 51, 38};

   typedef struct packed {
      logic [11:0] sample;
      logic        clipped;
   } audio_result_type;

   // a typed-in expectation travels with its sample until it is accepted
   typedef struct packed {
      logic             typed;
      audio_result_type want;
   } result_hint_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [10:0] echo_delay;
      logic [8:0]  echo_gain;
      logic [9:0]  vib_low;
      logic [8:0]  vib_stride;
      logic [15:0] vib_hold;
   } effect_cfg_type;

   // cfg_sel of zero keeps the current settings, otherwise picks DirectedCfg[cfg_sel-1]
   typedef struct packed {
      logic [3:0]       cfg_sel;
      logic [11:0]      sample;
      logic             typed;
      audio_result_type want;
   } directed_row_type;

   localparam effect_cfg_type DirectedCfg [8] = '{
      '{MODE_PASS,    11'd0,    9'd256, 10'd0,    9'd0,   16'd1},
      '{MODE_ECHO,    11'd0,    9'd256, 10'd0,    9'd0,   16'd1},
      '{MODE_ECHO,    11'd1,    9'd511, 10'd0,    9'd0,   16'd1},
      '{MODE_ECHO,    11'd2047, 9'd0,   10'd0,    9'd0,   16'd1},
      '{MODE_ECHO,    11'd2047, 9'd128, 10'd0,    9'd0,   16'd1},
      '{MODE_REVERB,  11'd441,  9'd128, 10'd441,  9'd88,  16'd8192},
      '{MODE_VIBRATO, 11'd0,    9'd0,   10'd1023, 9'd511, 16'd0},
      '{MODE_VIBRATO, 11'd0,    9'd0,   10'd0,    9'd0,   16'd65535}
   };

   localparam directed_row_type DirectedRows [22] = '{
      // reset settings are pass-through
      '{4'd0, 12'h123, 1'b1, {12'h123, 1'b0}},
      '{4'd1, 12'h000, 1'b1, {12'h000, 1'b0}},
      '{4'd0, 12'hFFF, 1'b1, {12'hFFF, 1'b0}},
      '{4'd0, 12'hA5A, 1'b0, 13'd0},
      // echo with zero delay and unity gain doubles the input
      '{4'd2, 12'hFFF, 1'b1, {12'hFFF, 1'b1}},
      '{4'd0, 12'h000, 1'b1, {12'h000, 1'b0}},
      '{4'd0, 12'h555, 1'b0, 13'd0},
      // gain above one, one-sample delay
      '{4'd3, 12'h800, 1'b0, 13'd0},
      '{4'd0, 12'h800, 1'b0, 13'd0},
      // longest delay with zero gain leaves the input alone
      '{4'd4, 12'h4D2, 1'b1, {12'h4D2, 1'b0}},
      '{4'd5, 12'h064, 1'b0, 13'd0},
      // reverb, feedback through stored outputs
      '{4'd6, 12'hFFF, 1'b0, 13'd0},
      '{4'd0, 12'hFFF, 1'b0, 13'd0},
      '{4'd0, 12'h000, 1'b0, 13'd0},
      // first vibrato sample still sees zero delay; zero hold steps every sample
      '{4'd7, 12'hFFF, 1'b1, {12'hFFF, 1'b0}},
      '{4'd0, 12'h007, 1'b0, 13'd0},
      '{4'd0, 12'hFFF, 1'b0, 13'd0},
      '{4'd0, 12'h000, 1'b0, 13'd0},
      '{4'd0, 12'h800, 1'b0, 13'd0},
      '{4'd0, 12'h7FF, 1'b0, 13'd0},
      // longest hold
      '{4'd8, 12'h001, 1'b0, 13'd0},
      '{4'd0, 12'hFFF, 1'b0, 13'd0}
   };

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [11:0]              req_sample_in;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [11:0]              rsp_sample_out;
   logic                     rsp_clipped;
   logic                     csr_write;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   delay_line_audio_effects_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // model copy of the registers
   logic [1:0]  cfg_mode;
   logic [10:0] cfg_echo_delay;
   logic [8:0]  cfg_echo_gain;
   logic [9:0]  cfg_vib_low;
   logic [8:0]  cfg_vib_stride;
   logic [15:0] cfg_vib_hold;

   // model copy of the delay line and vibrato sequencer
   logic [11:0] hist_mem [Depth];
   int unsigned wr_ptr;
   int unsigned hold_count;
   int unsigned vib_level;
   logic        vib_down;
   logic        vib_running;

   audio_result_type pending_out [$];   // processed samples still owed by the core
   result_hint_type  typed_hints [$];   // one per driven sample, in order
   result_hint_type  hint;
   audio_result_type got;
   int               mismatch_count = 0;
   int               result_count   = 0;
   int               idle_cycles    = 0;
   logic             moved;
   logic             calm;              // no gaps on either side while set

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   //---------------------------------------------------------------------------
   // model of the core
   //---------------------------------------------------------------------------

   task automatic clear_model();
      cfg_mode       = MODE_PASS;
      cfg_echo_delay = 11'd441;
      cfg_echo_gain  = 9'd128;
      cfg_vib_low    = 10'd441;
      cfg_vib_stride = 9'd88;
      cfg_vib_hold   = 16'd8192;
      for (int i = 0; i < Depth; i++) hist_mem[i] = 12'd0;
      wr_ptr      = 0;
      hold_count  = 0;
      vib_level   = 1;          // starts on the middle level
      vib_down    = 1'b0;
      vib_running = 1'b0;
   endtask

   // delays past the end of the line stop at its last entry
   function automatic int unsigned limit_delay(input int unsigned lag);
      return (lag >= Depth) ? Depth - 1 : lag;
   endfunction

   // zero lag means the sample being processed right now
   function automatic int unsigned past_sample(input int unsigned lag, input logic [11:0] x);
      if (lag == 0) return x;
      return hist_mem[(wr_ptr + Depth - lag) % Depth];
   endfunction

   // triangle walk over the three levels, one step per hold period
   function automatic void vibrato_tick();
      int unsigned hold;
      hold = (cfg_vib_hold == 16'd0) ? 1 : cfg_vib_hold;
      hold_count = (hold_count + 1) & 16'hFFFF;
      if (hold_count < hold) return;
      hold_count  = 0;
      vib_running = 1'b1;
      if (!vib_down) vib_level = (vib_level >= 2) ? 2 : vib_level + 1;
      else           vib_level = (vib_level == 0) ? 0 : vib_level - 1;
      if (vib_level >= 2) vib_down = 1'b1;
      if (vib_level == 0) vib_down = 1'b0;
   endfunction

   function automatic audio_result_type render_sample(input logic [11:0] x);
      int unsigned      total;
      int unsigned      acc;
      int unsigned      gain;
      int unsigned      lag;
      int unsigned      lvl;
      logic [11:0]      keep;
      audio_result_type r;
      total     = x;
      r.clipped = 1'b0;
      case (cfg_mode)
         MODE_ECHO: begin
            gain  = (cfg_echo_gain > UNITY_GAIN) ? UNITY_GAIN : cfg_echo_gain;
            total = x + ((gain * past_sample(limit_delay(cfg_echo_delay), x)) >> 8);
         end
         MODE_REVERB: begin
            acc = 0;
            for (int k = 0; k < 4; k++)
               acc += ReverbGain[k] * past_sample(limit_delay(ReverbTap[k]), x);
            total = x + (acc >> 8);
         end
         MODE_VIBRATO: begin
            lag = 0;
            if (vib_running) begin
               lvl = (vib_level > 2) ? 2 : vib_level;
               lag = limit_delay(cfg_vib_low + lvl * cfg_vib_stride);
            end
            total = past_sample(lag, x);
            vibrato_tick();
         end
         default: ;
      endcase
      if (total > 4095) begin
         total     = 4095;
         r.clipped = 1'b1;
      end
      r.sample = total[11:0];
      // reverb feeds back its outputs, the other modes keep raw inputs
      keep = (cfg_mode == MODE_REVERB) ? total[11:0] : x;
      hist_mem[wr_ptr] = keep;
      wr_ptr = (wr_ptr + 1) % Depth;
      return r;
   endfunction

   //---------------------------------------------------------------------------
   // checking
   //---------------------------------------------------------------------------

   task automatic report(input string msg);
      mismatch_count++;
      if (mismatch_count <= MaxReports) $display("%s", msg);
   endtask

   task automatic check_result(input audio_result_type actual);
      audio_result_type want;
      if (pending_out.size() == 0) begin
         report($sformatf("result %0d: nothing expected, got sample %03h clipped %0b",
                          result_count, actual.sample, actual.clipped));
      end else begin
         want = pending_out.pop_front();
         if (actual.sample !== want.sample || actual.clipped !== want.clipped)
            report($sformatf("result %0d: expected sample %03h clipped %0b, got %03h %0b",
                             result_count, want.sample, want.clipped,
                             actual.sample, actual.clipped));
      end
      result_count++;
   endtask

   // everything is sampled at the rising edge, before the core's own updates land
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
         idle_cycles = 0;
      end else begin
         moved = 1'b0;
         if (csr_write) begin
            moved = 1'b1;
            case (csr_index)
               CSR_EFFECT_MODE:   cfg_mode       = csr_wdata[1:0];
               CSR_ECHO_DELAY:    cfg_echo_delay = csr_wdata[10:0];
               CSR_ECHO_GAIN:     cfg_echo_gain  = csr_wdata[8:0];
               CSR_VIB_LOW_DELAY: cfg_vib_low    = csr_wdata[9:0];
               CSR_VIB_STEP:      cfg_vib_stride = csr_wdata[8:0];
               CSR_VIB_HOLD:      cfg_vib_hold   = csr_wdata[15:0];
               default: ;
            endcase
         end
         // output side first, so a result leaving in the same cycle as a new
         // sample arrives is matched against older expectations only
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            check_result({rsp_sample_out, rsp_clipped});
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            hint  = (typed_hints.size() != 0) ? typed_hints.pop_front() : '0;
            got   = render_sample(req_sample_in);   // model state advances either way
            pending_out.push_back(hint.typed ? hint.want : got);
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
      end
   end

   //---------------------------------------------------------------------------
   // stimulus helpers
   //---------------------------------------------------------------------------

   // mostly back to back, sometimes short gaps, rarely long ones
   function automatic int idle_length();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [11:0] random_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6)  return 12'h000;
      if (r < 12) return 12'hFFF;
      return 12'($urandom_range(0, 4095));
   endfunction

   function automatic effect_cfg_type random_cfg();
      effect_cfg_type c;
      int             r;
      c.mode = 2'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      c.echo_delay = 11'((r < 10) ? 0 : (r < 18) ? 2047 :
                         (r < 70) ? $urandom_range(1, 64) : $urandom_range(65, 2047));
      r = $urandom_range(0, 99);
      c.echo_gain = 9'((r < 10) ? 0 : (r < 20) ? 256 : (r < 30) ? 511 :
                       $urandom_range(0, 511));
      r = $urandom_range(0, 99);
      c.vib_low = 10'((r < 10) ? 0 : (r < 20) ? 1023 : $urandom_range(0, 1023));
      r = $urandom_range(0, 99);
      c.vib_stride = 9'((r < 10) ? 0 : (r < 20) ? 511 : $urandom_range(0, 511));
      // short holds so the delay actually walks through its levels
      r = $urandom_range(0, 99);
      c.vib_hold = 16'((r < 8) ? 0 : (r < 12) ? 65535 :
                       (r < 16) ? $urandom_range(100, 8192) : $urandom_range(1, 12));
      return c;
   endfunction

   // one transaction on the sample input; valid stays up afterwards so the
   // next call can continue without a gap
   task automatic send_sample(input logic [11:0] x, input logic typed,
                              input audio_result_type want);
      int gap;
      typed_hints.push_back({typed, want});
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (req_stall);
   endtask

   // let every owed result come out, then a few quiet cycles
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_out.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CsrIndexWidth-1:0] idx, input logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // registers only change while the core has nothing in flight
   task automatic apply_config(input effect_cfg_type c);
      wait_drained();
      put_reg(CSR_EFFECT_MODE,   16'(c.mode));
      put_reg(CSR_ECHO_DELAY,    16'(c.echo_delay));
      put_reg(CSR_ECHO_GAIN,     16'(c.echo_gain));
      put_reg(CSR_VIB_LOW_DELAY, 16'(c.vib_low));
      put_reg(CSR_VIB_STEP,      16'(c.vib_stride));
      put_reg(CSR_VIB_HOLD,      c.vib_hold);
      csr_write <= 1'b0;
   endtask

   //---------------------------------------------------------------------------
   // output side back-pressure
   //---------------------------------------------------------------------------

   initial begin
      int hold_off;
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         hold_off = idle_length();
         if (hold_off > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // watchdog: a stuck handshake ends the run
   initial begin
      wait (idle_cycles >= IdleLimit);
      $display("delay_line_audio_effects_core: mismatch");
      $finish;
   end

   //---------------------------------------------------------------------------
   // main sequence
   //---------------------------------------------------------------------------

   initial begin
      int               sent;
      int               burst;
      directed_row_type row;
      req_valid     <= 1'b0;
      req_sample_in <= 12'd0;
      csr_write     <= 1'b0;
      csr_index     <= CSR_EFFECT_MODE;
      csr_wdata     <= 16'd0;
      calm           = 1'b0;
      reset         <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table: modes, register extremes, special cases
      for (int i = 0; i < $size(DirectedRows); i++) begin
         row = DirectedRows[i];
         if (row.cfg_sel != 4'd0) apply_config(DirectedCfg[row.cfg_sel - 1]);
         send_sample(row.sample, row.typed, row.want);
      end

      // random phases: new settings each phase, history carries across them
      sent = 0;
      while (sent < RandomItems) begin
         calm = ($urandom_range(0, 4) == 0);
         apply_config(random_cfg());
         burst = $urandom_range(15, 70);
         repeat (burst) send_sample(random_sample(), 1'b0, '0);
         sent += burst;
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && pending_out.size() == 0) begin
         $display("delay_line_audio_effects_core: match");
      end else begin
         $display("delay_line_audio_effects_core: mismatch");
      end
      $finish;
   end

endmodule
